>>> hdl/dpdcpf_pkg.sv
// ----------------------------------------------------------------------------
// DPD conservative pair force: shared types and constants
// Fixed-point formats, configuration register indexes and the per-stage
// step functions of the square-root and reciprocal pipelines.
// ----------------------------------------------------------------------------
package dpdcpf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 24;
   localparam int BOX_W     = 23;
   localparam int COEF_W    = 16;
   localparam int D_W       = POS_W + 1;     // raw offset
   localparam int DRW_W     = POS_W + 2;     // offset after minimum image
   localparam int DR_W      = FRAC_BITS + 1; // in-range offset
   localparam int SQ_W      = 2 * FRAC_BITS; // in-range squared distance
   localparam int ROOT_W    = FRAC_BITS;
   localparam int SREM_W    = ROOT_W + 4;
   localparam int DREM_W    = ROOT_W + 1;
   localparam int Q_W       = 2 * FRAC_BITS + 1;
   localparam int T_W       = FRAC_BITS + 3;
   localparam int FT_W      = T_W + COEF_W + 1;
   localparam int FU_W      = FT_W - 8;
   localparam int VP_W      = FU_W + DR_W;
   localparam int DL_W      = Q_W + 4;
   localparam int LP_W      = DL_W + COEF_W + 1;
   localparam int LA_W      = LP_W - 8;
   localparam int OUT_W     = 25;
   localparam int LAP_W     = 32;

   localparam int SQRT_STAGES = 8;
   localparam int SQRT_STEPS  = ROOT_W / SQRT_STAGES;
   localparam int DIV_STAGES  = 11;
   localparam int DIV_STEPS   = Q_W / DIV_STAGES;

   localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(655360);

   localparam logic [1:0] CSR_BOX_X = 2'd0;
   localparam logic [1:0] CSR_BOX_Y = 2'd1;
   localparam logic [1:0] CSR_BOX_Z = 2'd2;

   typedef struct packed {
      logic [2:0][DR_W-1:0] dr;
      logic [COEF_W-1:0]    coef;
      logic                 inr;
      logic [SQ_W-1:0]      val;
      logic [ROOT_W-1:0]    root;
      logic [SREM_W-1:0]    rem;
   } sqrt_type;

   typedef struct packed {
      logic [2:0][DR_W-1:0] dr;
      logic [COEF_W-1:0]    coef;
      logic                 inr;
      logic                 zero;
      logic [ROOT_W-1:0]    dvsr;
      logic [DREM_W-1:0]    rem;
      logic [Q_W-1:0]       num;
      logic [Q_W-1:0]       quo;
   } div_type;

   // Two result bits of the digit-by-digit square root.
   function automatic sqrt_type sqrt_stage_fn(input sqrt_type s);
      sqrt_type            o;
      logic [SREM_W-1:0]   trial;
      o = s;
      for (int i = 0; i < SQRT_STEPS; i++) begin
         o.rem = {o.rem[SREM_W-3:0], o.val[SQ_W-1 -: 2]};
         o.val = {o.val[SQ_W-3:0], 2'b00};
         trial = {{(SREM_W-ROOT_W-2){1'b0}}, o.root, 2'b01};
         if (o.rem >= trial) begin
            o.rem  = o.rem - trial;
            o.root = {o.root[ROOT_W-2:0], 1'b1};
         end else begin
            o.root = {o.root[ROOT_W-2:0], 1'b0};
         end
      end
      return o;
   endfunction

   // Three quotient bits of the restoring division 2^(2F) / r.
   function automatic div_type div_stage_fn(input div_type s);
      div_type           o;
      logic [DREM_W-1:0] sh;
      o = s;
      for (int i = 0; i < DIV_STEPS; i++) begin
         sh    = {o.rem[DREM_W-2:0], o.num[Q_W-1]};
         o.num = {o.num[Q_W-2:0], 1'b0};
         if (sh >= {1'b0, o.dvsr}) begin
            o.rem = sh - {1'b0, o.dvsr};
            o.quo = {o.quo[Q_W-2:0], 1'b1};
         end else begin
            o.rem = sh;
            o.quo = {o.quo[Q_W-2:0], 1'b0};
         end
      end
      return o;
   endfunction

endpackage

>>> hdl/dpd_conservative_pair_force.sv
// ----------------------------------------------------------------------------
// DPD conservative pair force
// Pipelined soft-repulsion force, virial and Laplacian term for one particle
// pair per cycle while not stalled, with a per-type-pair coefficient table.
// ----------------------------------------------------------------------------
// A func=0 item (a particle pair) enters every cycle unless req_stall is high;
// one stage forms the offsets, one applies the minimum image, two form r squared,
// eight stages take the square root two bits at a time, eleven stages form 1/r
// three quotient bits at a time, three multiply and one saturates into the
// output register. A func=1 item writes the coefficient table in the cycle it
// is accepted and gives no result; pairs accepted after it see the new
// coefficient. Each stage holds only while the stage after it is full and held,
// so bubbles close up and the input keeps flowing while a finished result waits
// on rsp_stall, until the stages are full. Box lengths must be written through
// the csr port while no item is in flight (unenforced); csr_ready is always high.
// ----------------------------------------------------------------------------
module dpd_conservative_pair_force #(
   parameter int TYPE_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   // pair / table-write items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [23:0] req_pos_i_x,
   input  logic [23:0] req_pos_i_y,
   input  logic [23:0] req_pos_i_z,
   input  logic [23:0] req_pos_j_x,
   input  logic [23:0] req_pos_j_y,
   input  logic [23:0] req_pos_j_z,
   input  logic [1:0]  req_type_i,
   input  logic [1:0]  req_type_j,
   input  logic [15:0] req_coef_value,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [24:0] rsp_force_x,
   output logic [24:0] rsp_force_y,
   output logic [24:0] rsp_force_z,
   output logic [24:0] rsp_virial_x,
   output logic [24:0] rsp_virial_y,
   output logic [24:0] rsp_virial_z,
   output logic [31:0] rsp_lap_term,
   output logic        rsp_in_range,
   output logic        rsp_lap_saturated,
   // box length registers
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [22:0] csr_data
);

   localparam int ENTRIES = TYPE_COUNT * TYPE_COUNT;
   localparam int IDX_W   = $clog2(ENTRIES);

   // stage numbering
   localparam int S_SQ0 = 4;
   localparam int S_DV0 = S_SQ0 + dpdcpf_pkg::SQRT_STAGES;
   localparam int S_M1  = S_DV0 + dpdcpf_pkg::DIV_STAGES;
   localparam int S_M2  = S_M1 + 1;
   localparam int S_M3  = S_M2 + 1;
   localparam int S_OUT = S_M3 + 1;
   localparam int NST   = S_OUT + 1;

   localparam int ONE = 1 << dpdcpf_pkg::FRAC_BITS;

   // ---------------------------------------------------------------------
   // Flow control: a stage loads when it is empty or its successor loads.
   // ---------------------------------------------------------------------
   logic [NST-1:0] v_ff;
   logic [NST-1:0] adv;

   assign adv[S_OUT] = ~v_ff[S_OUT] | ~rsp_stall;
   for (genvar k = 0; k < S_OUT; k++) begin : g_adv
      assign adv[k] = ~v_ff[k] | adv[k+1];
   end

   assign req_stall = ~adv[0];

   logic accept;
   assign accept = req_valid & adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= req_valid & ~req_func;
         end
         for (int k = 1; k < NST; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Box length registers
   // ---------------------------------------------------------------------
   logic [2:0][dpdcpf_pkg::BOX_W-1:0] box_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= {3{dpdcpf_pkg::BOX_RESET}};
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dpdcpf_pkg::CSR_BOX_X: box_ff[0] <= csr_data;
            dpdcpf_pkg::CSR_BOX_Y: box_ff[1] <= csr_data;
            dpdcpf_pkg::CSR_BOX_Z: box_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Coefficient table: written on accept of a func=1 item, read for a pair
   // at accept, so a later pair always sees an earlier write.
   // ---------------------------------------------------------------------
   logic [dpdcpf_pkg::COEF_W-1:0] coef_ff [ENTRIES];
   logic                          type_ok;
   logic [IDX_W-1:0]              tbl_idx;
   logic [dpdcpf_pkg::COEF_W-1:0] coef_rd;

   assign type_ok = (int'(req_type_i) < TYPE_COUNT) && (int'(req_type_j) < TYPE_COUNT);
   assign tbl_idx = IDX_W'(IDX_W'(req_type_i) * IDX_W'(TYPE_COUNT) + IDX_W'(req_type_j));
   assign coef_rd = type_ok ? coef_ff[tbl_idx] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '{default: '0};
      end else if (accept && req_func && type_ok) begin
         coef_ff[tbl_idx] <= req_coef_value;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 0: raw offsets pos_i - pos_j
   // ---------------------------------------------------------------------
   logic [2:0][dpdcpf_pkg::POS_W-1:0] pos_i;
   logic [2:0][dpdcpf_pkg::POS_W-1:0] pos_j;
   logic [2:0][dpdcpf_pkg::D_W-1:0]   d0_ff;
   logic [dpdcpf_pkg::COEF_W-1:0]     coef0_ff;

   assign pos_i = {req_pos_i_z, req_pos_i_y, req_pos_i_x};
   assign pos_j = {req_pos_j_z, req_pos_j_y, req_pos_j_x};

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int k = 0; k < 3; k++) begin
            d0_ff[k] <= {pos_i[k][dpdcpf_pkg::POS_W-1], pos_i[k]}
                      - {pos_j[k][dpdcpf_pkg::POS_W-1], pos_j[k]};
         end
         coef0_ff <= coef_rd;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: one minimum-image correction per axis
   // ---------------------------------------------------------------------
   function automatic logic [dpdcpf_pkg::DRW_W-1:0] min_image_fn(
      input logic [dpdcpf_pkg::D_W-1:0]   d,
      input logic [dpdcpf_pkg::BOX_W-1:0] len
   );
      logic signed [dpdcpf_pkg::DRW_W-1:0] ds;
      logic signed [dpdcpf_pkg::DRW_W-1:0] hs;
      logic signed [dpdcpf_pkg::DRW_W-1:0] ls;
      ds = $signed({d[dpdcpf_pkg::D_W-1], d});
      hs = $signed({{(dpdcpf_pkg::DRW_W-dpdcpf_pkg::BOX_W+1){1'b0}},
                    len[dpdcpf_pkg::BOX_W-1:1]});
      ls = $signed({{(dpdcpf_pkg::DRW_W-dpdcpf_pkg::BOX_W){1'b0}}, len});
      if (ds > hs) begin
         return ds - ls;
      end else if (ds < -hs) begin
         return ds + ls;
      end
      return ds;
   endfunction

   logic [2:0][dpdcpf_pkg::DRW_W-1:0] dr1_ff;
   logic [dpdcpf_pkg::COEF_W-1:0]     coef1_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int k = 0; k < 3; k++) begin
            dr1_ff[k] <= min_image_fn(d0_ff[k], box_ff[k]);
         end
         coef1_ff <= coef0_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: per-axis squares; any |dr| >= 1 is out of range outright
   // ---------------------------------------------------------------------
   logic [2:0]                       small_in;
   logic [2:0][dpdcpf_pkg::SQ_W-1:0] sq_in;
   logic [2:0]                       small2_ff;
   logic [2:0][dpdcpf_pkg::SQ_W-1:0] sq2_ff;
   logic [2:0][dpdcpf_pkg::DR_W-1:0] dr2_ff;
   logic [dpdcpf_pkg::COEF_W-1:0]    coef2_ff;

   always_comb begin
      logic signed [dpdcpf_pkg::DR_W-1:0]   dn;
      logic signed [2*dpdcpf_pkg::DR_W-1:0] prod;
      for (int k = 0; k < 3; k++) begin
         small_in[k] = ($signed(dr1_ff[k]) < $signed(dpdcpf_pkg::DRW_W'(ONE)))
                    && ($signed(dr1_ff[k]) > -$signed(dpdcpf_pkg::DRW_W'(ONE)));
         dn          = $signed(dr1_ff[k][dpdcpf_pkg::DR_W-1:0]);
         prod        = dn * dn;
         sq_in[k]    = prod[dpdcpf_pkg::SQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         small2_ff <= small_in;
         sq2_ff    <= sq_in;
         for (int k = 0; k < 3; k++) begin
            dr2_ff[k] <= dr1_ff[k][dpdcpf_pkg::DR_W-1:0];
         end
         coef2_ff <= coef1_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: r squared and the range test; seed the square root
   // ---------------------------------------------------------------------
   logic [dpdcpf_pkg::SQ_W+1:0] sum_in;
   dpdcpf_pkg::sqrt_type        seed_in;
   dpdcpf_pkg::sqrt_type        seed_ff;

   always_comb begin
      sum_in       = (dpdcpf_pkg::SQ_W+2)'(sq2_ff[0]) + (dpdcpf_pkg::SQ_W+2)'(sq2_ff[1])
                   + (dpdcpf_pkg::SQ_W+2)'(sq2_ff[2]);
      seed_in.dr   = dr2_ff;
      seed_in.coef = coef2_ff;
      seed_in.inr  = (&small2_ff) && (sum_in[dpdcpf_pkg::SQ_W+1:dpdcpf_pkg::SQ_W] == 2'b00);
      seed_in.val  = sum_in[dpdcpf_pkg::SQ_W-1:0];
      seed_in.root = '0;
      seed_in.rem  = '0;
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         seed_ff <= seed_in;
      end
   end

   // ---------------------------------------------------------------------
   // Square root pipeline: r = floor(sqrt(dr2))
   // ---------------------------------------------------------------------
   dpdcpf_pkg::sqrt_type sq_ff [dpdcpf_pkg::SQRT_STAGES];

   for (genvar s = 0; s < dpdcpf_pkg::SQRT_STAGES; s++) begin : g_sqrt
      dpdcpf_pkg::sqrt_type sq_in_s;
      if (s == 0) begin : g_first
         assign sq_in_s = dpdcpf_pkg::sqrt_stage_fn(seed_ff);
      end else begin : g_next
         assign sq_in_s = dpdcpf_pkg::sqrt_stage_fn(sq_ff[s-1]);
      end
      always_ff @(posedge clock) begin
         if (adv[S_SQ0+s]) begin
            sq_ff[s] <= sq_in_s;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Reciprocal pipeline: inv = floor(2^(2F) / r); r = 0 is flagged
   // ---------------------------------------------------------------------
   dpdcpf_pkg::div_type dv_seed;
   dpdcpf_pkg::div_type dv_ff [dpdcpf_pkg::DIV_STAGES];

   always_comb begin
      dv_seed.dr   = sq_ff[dpdcpf_pkg::SQRT_STAGES-1].dr;
      dv_seed.coef = sq_ff[dpdcpf_pkg::SQRT_STAGES-1].coef;
      dv_seed.inr  = sq_ff[dpdcpf_pkg::SQRT_STAGES-1].inr;
      dv_seed.zero = (sq_ff[dpdcpf_pkg::SQRT_STAGES-1].root == '0);
      dv_seed.dvsr = sq_ff[dpdcpf_pkg::SQRT_STAGES-1].root;
      dv_seed.rem  = '0;
      dv_seed.num  = {1'b1, {(dpdcpf_pkg::Q_W-1){1'b0}}};
      dv_seed.quo  = '0;
   end

   for (genvar s = 0; s < dpdcpf_pkg::DIV_STAGES; s++) begin : g_div
      dpdcpf_pkg::div_type dv_in_s;
      if (s == 0) begin : g_first
         assign dv_in_s = dpdcpf_pkg::div_stage_fn(dv_seed);
      end else begin : g_next
         assign dv_in_s = dpdcpf_pkg::div_stage_fn(dv_ff[s-1]);
      end
      always_ff @(posedge clock) begin
         if (adv[S_DV0+s]) begin
            dv_ff[s] <= dv_in_s;
         end
      end
   end

   // ---------------------------------------------------------------------
   // M1: t = floor((inv - 1) * dr), d = 6 - 4 * inv
   // ---------------------------------------------------------------------
   dpdcpf_pkg::div_type              dv_last;
   logic [2:0][dpdcpf_pkg::T_W-1:0]  t_in;
   logic [dpdcpf_pkg::DL_W-1:0]      dl_in;
   logic [2:0][dpdcpf_pkg::T_W-1:0]  t_ff;
   logic [dpdcpf_pkg::DL_W-1:0]      dl_ff;
   logic [2:0][dpdcpf_pkg::DR_W-1:0] dr_m1_ff;
   logic [dpdcpf_pkg::COEF_W-1:0]    coef_m1_ff;
   logic                             inr_m1_ff;
   logic                             zero_m1_ff;

   assign dv_last = dv_ff[dpdcpf_pkg::DIV_STAGES-1];

   always_comb begin
      logic [dpdcpf_pkg::Q_W-1:0]                        invm;
      logic signed [dpdcpf_pkg::Q_W+dpdcpf_pkg::DR_W:0]  pt;
      invm = dv_last.quo - dpdcpf_pkg::Q_W'(ONE);
      for (int k = 0; k < 3; k++) begin
         pt      = $signed({1'b0, invm}) * $signed(dv_last.dr[k]);
         t_in[k] = pt[dpdcpf_pkg::FRAC_BITS +: dpdcpf_pkg::T_W];
      end
      dl_in = dpdcpf_pkg::DL_W'(6 * ONE) - {2'b00, dv_last.quo, 2'b00};
   end

   always_ff @(posedge clock) begin
      if (adv[S_M1]) begin
         t_ff       <= t_in;
         dl_ff      <= dl_in;
         dr_m1_ff   <= dv_last.dr;
         coef_m1_ff <= dv_last.coef;
         inr_m1_ff  <= dv_last.inr;
         zero_m1_ff <= dv_last.zero;
      end
   end

   // ---------------------------------------------------------------------
   // M2: multiply by the coefficient
   // ---------------------------------------------------------------------
   logic [2:0][dpdcpf_pkg::FT_W-1:0] ft_ff;
   logic [dpdcpf_pkg::LP_W-1:0]      lp_ff;
   logic [2:0][dpdcpf_pkg::DR_W-1:0] dr_m2_ff;
   logic                             coef_nz_m2_ff;
   logic                             inr_m2_ff;
   logic                             zero_m2_ff;

   always_ff @(posedge clock) begin
      if (adv[S_M2]) begin
         for (int k = 0; k < 3; k++) begin
            ft_ff[k] <= $signed(t_ff[k]) * $signed({1'b0, coef_m1_ff});
         end
         lp_ff         <= $signed(dl_ff) * $signed({1'b0, coef_m1_ff});
         dr_m2_ff      <= dr_m1_ff;
         coef_nz_m2_ff <= (coef_m1_ff != '0);
         inr_m2_ff     <= inr_m1_ff;
         zero_m2_ff    <= zero_m1_ff;
      end
   end

   // ---------------------------------------------------------------------
   // M3: drop the Q8.8 scale, form force * dr for the virial
   // ---------------------------------------------------------------------
   logic [2:0][dpdcpf_pkg::FU_W-1:0] fu_in;
   logic [2:0][dpdcpf_pkg::FU_W-1:0] fu_ff;
   logic [2:0][dpdcpf_pkg::VP_W-1:0] vp_ff;
   logic [dpdcpf_pkg::LA_W-1:0]      la_ff;
   logic                             coef_nz_m3_ff;
   logic                             inr_m3_ff;
   logic                             zero_m3_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         fu_in[k] = ft_ff[k][dpdcpf_pkg::FT_W-1:8];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[S_M3]) begin
         for (int k = 0; k < 3; k++) begin
            fu_ff[k] <= fu_in[k];
            vp_ff[k] <= $signed(fu_in[k]) * $signed(dr_m2_ff[k]);
         end
         la_ff         <= lp_ff[dpdcpf_pkg::LP_W-1:8];
         coef_nz_m3_ff <= coef_nz_m2_ff;
         inr_m3_ff     <= inr_m2_ff;
         zero_m3_ff    <= zero_m2_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Output stage: saturate and zero out-of-range pairs
   // ---------------------------------------------------------------------
   function automatic logic [dpdcpf_pkg::OUT_W-1:0] sat_out_fn(
      input logic signed [dpdcpf_pkg::LA_W-1:0] v
   );
      if (v > $signed(dpdcpf_pkg::LA_W'((1 << (dpdcpf_pkg::OUT_W-1)) - 1))) begin
         return {1'b0, {(dpdcpf_pkg::OUT_W-1){1'b1}}};
      end else if (v < -$signed(dpdcpf_pkg::LA_W'(1 << (dpdcpf_pkg::OUT_W-1)))) begin
         return {1'b1, {(dpdcpf_pkg::OUT_W-1){1'b0}}};
      end
      return v[dpdcpf_pkg::OUT_W-1:0];
   endfunction

   logic [2:0][dpdcpf_pkg::OUT_W-1:0] force_in;
   logic [2:0][dpdcpf_pkg::OUT_W-1:0] vir_in;
   logic [dpdcpf_pkg::LAP_W-1:0]      lap_in;
   logic                              lsat_in;
   logic [2:0][dpdcpf_pkg::OUT_W-1:0] force_ff;
   logic [2:0][dpdcpf_pkg::OUT_W-1:0] vir_ff;
   logic [dpdcpf_pkg::LAP_W-1:0]      lap_ff;
   logic                              inr_ff;
   logic                              lsat_ff;

   always_comb begin
      logic signed [dpdcpf_pkg::LA_W-1:0] la;
      la = $signed(la_ff);
      for (int k = 0; k < 3; k++) begin
         force_in[k] = inr_m3_ff ? sat_out_fn(dpdcpf_pkg::LA_W'($signed(fu_ff[k]))) : '0;
         vir_in[k]   = inr_m3_ff
                     ? sat_out_fn(dpdcpf_pkg::LA_W'($signed(
                          vp_ff[k][dpdcpf_pkg::VP_W-1:dpdcpf_pkg::FRAC_BITS])))
                     : '0;
      end
      lap_in  = '0;
      lsat_in = 1'b0;
      priority if (!inr_m3_ff) begin
         lap_in  = '0;
         lsat_in = 1'b0;
      end else if (zero_m3_ff) begin
         // coincident particles: a * (minus infinity)
         lap_in  = coef_nz_m3_ff ? {1'b1, {(dpdcpf_pkg::LAP_W-1){1'b0}}} : '0;
         lsat_in = coef_nz_m3_ff;
      end else if (la > $signed(dpdcpf_pkg::LA_W'({1'b0, {(dpdcpf_pkg::LAP_W-1){1'b1}}}))) begin
         lap_in  = {1'b0, {(dpdcpf_pkg::LAP_W-1){1'b1}}};
         lsat_in = 1'b1;
      end else if (la < -$signed(dpdcpf_pkg::LA_W'({1'b1, {(dpdcpf_pkg::LAP_W-1){1'b0}}}))) begin
         lap_in  = {1'b1, {(dpdcpf_pkg::LAP_W-1){1'b0}}};
         lsat_in = 1'b1;
      end else begin
         lap_in  = la_ff[dpdcpf_pkg::LAP_W-1:0];
         lsat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[S_OUT]) begin
         force_ff <= force_in;
         vir_ff   <= vir_in;
         lap_ff   <= lap_in;
         inr_ff   <= inr_m3_ff;
         lsat_ff  <= lsat_in;
      end
   end

   assign rsp_valid         = v_ff[S_OUT];
   assign rsp_force_x       = force_ff[0];
   assign rsp_force_y       = force_ff[1];
   assign rsp_force_z       = force_ff[2];
   assign rsp_virial_x      = vir_ff[0];
   assign rsp_virial_y      = vir_ff[1];
   assign rsp_virial_z      = vir_ff[2];
   assign rsp_lap_term      = lap_ff;
   assign rsp_in_range      = inr_ff;
   assign rsp_lap_saturated = lsat_ff;

endmodule
